// ===== hw/rtl/sbs_pkg.sv =====
// Shared types and constants for the descending sort and binary search unit.
`default_nettype none
package sbs_pkg;
   localparam int DATA_W     = 32;
   localparam int POS_W      = 6;
   localparam int RSP_DATA_W = 40;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_SEARCH   = 1'b1;
   localparam logic KIND_ELEM   = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef struct packed {
      logic shift_in;
      logic shift_out;
      logic sort;
      logic phase;
   } sbs_ctl_type;
endpackage
`default_nettype wire

// ===== hw/rtl/sbs_cell.sv =====
// One cell of the sorting chain: holds one element, shifts or compare-exchanges with neighbors.
`default_nettype none
module sbs_cell #(
   parameter bit IS_ODD   = 1'b0,
   parameter bit IS_FIRST = 1'b0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sbs_pkg::sbs_ctl_type ctl,
   input  wire sbs_pkg::data_type   left_data,
   input  wire logic                left_valid,
   input  wire sbs_pkg::data_type   right_data,
   input  wire logic                right_valid,
   output sbs_pkg::data_type        data,
   output logic                     valid
);
   import sbs_pkg::*;

   data_type data_ff, data_in;
   logic     valid_ff, valid_in;
   logic     left_role;
   logic     right_gt_me;
   logic     me_gt_left;

   // invalid cells rank below every element
   assign right_gt_me = right_valid && (!valid_ff || (right_data > data_ff));
   assign me_gt_left  = valid_ff && (!left_valid || (data_ff > left_data));
   assign left_role   = (IS_ODD == ctl.phase);

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctl.shift_in) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctl.shift_out) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctl.sort) begin
         if (left_role) begin
            if (right_gt_me) begin
               data_in  = right_data;
               valid_in = right_valid;
            end
         end else if (!IS_FIRST && me_gt_left) begin
            data_in  = left_data;
            valid_in = left_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data  = data_ff;
   assign valid = valid_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/sort_descending_and_binary_search_unit.sv =====
// Top level: cell chain sorter, element memory and binary search sequencer.
//
// channel | dir | tdata                                        | tuser | tlast
// req     | in  | [31:0] value                                 | op    | last
// rsp     | out | [31:0] element, [37:32] position, [38] found | kind  | final_res
//
// Load: a non-last load gives no result.
// Last load: rounds of odd-even exchange in the cell chain, then one result per cycle
// while rsp is not stalled (count results) as the chain shifts out toward cell 0.
// Search: each probe is a memory read (ST_SADDR) then a compare (ST_SCMP), up to
// log2(DEPTH)+1 probes; ST_SDONE posts the answer, and a miss closes via one more ST_SADDR.
// One item in flight; req_tready is low while busy.
// Reset clears control state; no clearing pass. Stalls on rsp freeze the sequencer.
`default_nettype none
module sort_descending_and_binary_search_unit #(
   parameter int DEPTH = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [sbs_pkg::DATA_W-1:0]        req_tdata,  // [31:0] value
   input  wire logic                              req_tuser,  // op
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [sbs_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // element, position, found, pad
   output logic                                   rsp_tuser,  // kind
   output logic                                   rsp_tlast
);
   import sbs_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SORT  = 3'd1;
   localparam logic [2:0] ST_EMIT  = 3'd2;
   localparam logic [2:0] ST_SADDR = 3'd3;
   localparam logic [2:0] ST_SCMP  = 3'd4;
   localparam logic [2:0] ST_SDONE = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                fresh_ff, fresh_in;
   logic [CW-1:0]       rnd_ff, rnd_in;
   logic [AW-1:0]       emit_ff, emit_in;
   logic signed [SW-1:0] low_ff, low_in, high_ff, high_in;
   logic [AW-1:0]       mid_ff, mid_in;
   data_type            target_ff, target_in;
   logic                hit_ff, hit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   data_type            rsp_elem_ff, rsp_elem_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_last_ff, rsp_last_in;

   data_type            mem [DEPTH];
   data_type            mem_q;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   data_type            mem_wdata;

   sbs_ctl_type         ctl;
   data_type            cell_data [DEPTH];
   logic                cell_valid [DEPTH];

   logic                req_fire, slot_free;
   logic [CW-1:0]       base_count;
   logic [SW:0]         mid_sum;
   logic [AW-1:0]       mid_calc;
   logic [SW-1:0]       mid_ext;

   assign req_fire   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign base_count = fresh_ff ? '0 : count_ff;
   assign mid_sum    = {1'b0, low_ff} + {1'b0, high_ff};
   assign mid_calc   = mid_sum[AW:1];
   assign mid_ext    = SW'(mid_ff);

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         data_type l_data, r_data;
         logic     l_valid, r_valid;
         if (gi == 0) begin : g_head
            assign l_data  = req_tdata;
            assign l_valid = 1'b1;
         end else begin : g_mid
            assign l_data  = cell_data[gi-1];
            assign l_valid = cell_valid[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_tail
            assign r_data  = '0;
            assign r_valid = 1'b0;
         end else begin : g_body
            assign r_data  = cell_data[gi+1];
            assign r_valid = cell_valid[gi+1];
         end
         sbs_cell #(
            .IS_ODD   (gi % 2 == 1),
            .IS_FIRST (gi == 0)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data        (cell_data[gi]),
            .valid       (cell_valid[gi])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q <= mem[mid_calc];
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      fresh_in     = fresh_ff;
      rnd_in       = rnd_ff;
      emit_in      = emit_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      target_in    = target_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_elem_in  = rsp_elem_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;
      ctl          = '0;
      mem_we       = 1'b0;
      mem_waddr    = base_count[AW-1:0];
      mem_wdata    = req_tdata;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               target_in = req_tdata;
               if (req_tuser == OP_LOAD) begin
                  fresh_in = 1'b0;
                  count_in = base_count;
                  if (base_count < CW'(DEPTH)) begin
                     ctl.shift_in = 1'b1;
                     mem_we       = 1'b1;
                     count_in     = base_count + CW'(1);
                  end
                  if (req_tlast) begin
                     rnd_in   = '0;
                     state_in = ST_SORT;
                  end
               end else begin
                  low_in   = '0;
                  high_in  = $signed(SW'(count_ff)) - SW'(1);
                  hit_in   = 1'b0;
                  mid_in   = '0;
                  state_in = ST_SADDR;
               end
            end
         end
         ST_SORT: begin
            ctl.sort  = 1'b1;
            ctl.phase = rnd_ff[0];
            rnd_in    = rnd_ff + CW'(1);
            if (rnd_ff + CW'(1) >= count_ff) begin
               emit_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               ctl.shift_out = 1'b1;
               mem_we        = 1'b1;
               mem_waddr     = emit_ff;
               mem_wdata     = cell_data[0];
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_ELEM;
               rsp_elem_in   = cell_data[0];
               rsp_pos_in    = POS_W'(emit_ff);
               rsp_found_in  = 1'b0;
               rsp_last_in   = (CW'(emit_ff) + CW'(1) == count_ff);
               emit_in       = emit_ff + AW'(1);
               if (CW'(emit_ff) + CW'(1) == count_ff) begin
                  fresh_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SADDR: begin
            if (low_ff > high_ff) begin
               state_in = ST_SDONE;
            end else begin
               mid_in   = mid_calc;
               state_in = ST_SCMP;
            end
         end
         ST_SCMP: begin
            if (mem_q == target_ff) begin
               hit_in   = 1'b1;
               state_in = ST_SDONE;
            end else begin
               if (mem_q < target_ff) begin
                  high_in = $signed(mid_ext - SW'(1));
               end else begin
                  low_in = $signed(mid_ext + SW'(1));
               end
               state_in = ST_SADDR;
            end
         end
         ST_SDONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_SEARCH;
               rsp_elem_in  = target_ff;
               rsp_pos_in   = hit_ff ? POS_W'(mid_ff) : '0;
               rsp_found_in = hit_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rnd_ff       <= rnd_in;
      emit_ff      <= emit_in;
      low_ff       <= low_in;
      high_ff      <= high_in;
      mid_ff       <= mid_in;
      target_ff    <= target_in;
      hit_ff       <= hit_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_elem_ff  <= rsp_elem_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         fresh_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - DATA_W - POS_W - 1){1'b0}},
                        rsp_found_ff, rsp_pos_ff, rsp_elem_ff};
endmodule
`default_nettype wire

// ===== hw/rtl/sbs_checker.sv =====
// Port-level checks for the descending sort and binary search unit, with bind.
`default_nettype none
module sbs_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              req_tuser,
   input wire logic                              req_tlast,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [sbs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic                              rsp_tuser,
   input wire logic                              rsp_tlast
);
   import sbs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transfer changed while stalled");

   a_search_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SEARCH) |-> rsp_tlast)
      else $error("search answer not marked final");

   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SEARCH) && !rsp_tdata[38]
         |-> rsp_tdata[37:32] == '0)
      else $error("search miss with nonzero position");

   a_elem_nofound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_ELEM) |-> !rsp_tdata[38])
      else $error("sorted element carries found flag");

   a_close_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_LOAD) && req_tlast |=> !req_tready)
      else $error("input taken during sort after closing load");
endmodule

bind sort_descending_and_binary_search_unit sbs_checker u_sbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
